// ===== design/first_fit_region_allocator_assert.svh =====
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// Concurrent check sampled on the rising edge, held off while reset is active.
`define FFRA_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent check that also holds while reset is active.
`define FFRA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== design/ffra_pkg.sv =====
package ffra_pkg;

    localparam int unsigned OFFS_W  = 24;
    localparam int unsigned LIMIT_W = 25;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 25'd16777216;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd409600;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_RELOCATE = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_GRANTED  = 3'd0,
        STAT_NOMEM    = 3'd1,
        STAT_FREED    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TAIL,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_FREE_RD,
        S_FREE_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_DONE,
        S_FIN
    } state_t;

endpackage

// ===== design/first_fit_region_allocator.sv =====
// An item reads and checks table entries in turn while scanning (S_SCAN_RD, S_SCAN_CHK),
// shifts entries with a read and a write each, and ends in the result state S_FIN.
// Throughput: one item at a time, set by the single read and write port of the region table.
// The next item is accepted while a finished result still waits for its transfer.
// Reset empties the table at once (count cleared) and sets pool_limit to 409600.
module first_fit_region_allocator #(
    parameter int unsigned MAX_REGIONS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [23:0] alloc_bytes,
    input  logic [23:0] region_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [23:0] granted_start,
    output logic [23:0] region_size
);
    import ffra_pkg::*;

    localparam int unsigned AW = $clog2(MAX_REGIONS);
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

    logic [LIMIT_W-1:0] pool_limit_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [47:0]        mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            pool_limit_reg <= cfg_wdata;
    end

    ffra_mem #(
        .DEPTH (MAX_REGIONS),
        .AW    (AW),
        .DW    (48)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffra_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .pool_limit    (pool_limit_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .alloc_bytes   (alloc_bytes),
        .region_start  (region_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_start (granted_start),
        .region_size   (region_size),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

endmodule

// ===== design/ffra_mem.sv =====
module ffra_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 48
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffra_ctrl.sv =====
module ffra_ctrl #(
    parameter int unsigned MAX_REGIONS = 64,
    parameter int unsigned AW          = 6,
    parameter int unsigned CW          = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ffra_pkg::LIMIT_W-1:0] pool_limit,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [23:0]              alloc_bytes,
    input  logic [23:0]              region_start,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [23:0]              granted_start,
    output logic [23:0]              region_size,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic [47:0]              mem_wdata,
    output logic [AW-1:0]            mem_raddr,
    input  logic [47:0]              mem_rdata
);
    import ffra_pkg::*;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [LIMIT_W-1:0]    prev_end_reg, prev_end_next;
    logic [OFFS_W-1:0]     size_reg, size_next;
    logic [OFFS_W-1:0]     where_reg, where_next;
    logic [OFFS_W-1:0]     new_start_reg, new_start_next;
    logic [1:0]            op_reg, op_next;
    logic                  reloc_reg, reloc_next;
    status_t               res_stat_reg, res_stat_next;
    logic [OFFS_W-1:0]     res_gstart_reg, res_gstart_next;
    logic [OFFS_W-1:0]     res_size_reg, res_size_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_stat_reg, out_stat_next;
    logic [OFFS_W-1:0]     out_gstart_reg, out_gstart_next;
    logic [OFFS_W-1:0]     out_size_reg, out_size_next;

    logic [OFFS_W-1:0]     rd_start, rd_size;
    logic [LIMIT_W-1:0]    limit;
    logic [LIMIT_W-1:0]    rd_end;
    logic [LIMIT_W:0]      fit_end;
    logic [CW-1:0]         idx_inc, idx_dec;
    logic                  out_free;

    assign rd_start = mem_rdata[47:24];
    assign rd_size  = mem_rdata[23:0];
    assign limit    = (pool_limit > LIMIT_CAP) ? LIMIT_CAP : pool_limit;
    assign rd_end   = {1'b0, rd_start} + {1'b0, rd_size};
    assign fit_end  = {1'b0, prev_end_reg} + {2'b00, size_reg};
    assign idx_inc  = idx_reg + ONE;
    assign idx_dec  = idx_reg - ONE;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_ALLOC:    state_next = S_ALLOC;
                        OP_FREE,
                        OP_RELOCATE: state_next = (cnt_reg == '0) ? S_FIN : S_FREE_RD;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (cnt_reg == MAX_CNT || size_reg == '0)
                    state_next = S_FIN;
                else if (cnt_reg == '0)
                    state_next = ({2'b00, size_reg} < {1'b0, limit}) ? S_INS_PUT : S_FIN;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (idx_reg == '0 && size_reg < rd_start)
                    state_next = S_INS_RD;
                else if (idx_reg != '0 && fit_end <= {2'b00, rd_start})
                    state_next = S_INS_RD;
                else if (idx_inc == cnt_reg)
                    state_next = S_TAIL;
                else
                    state_next = S_SCAN_RD;
            end
            S_TAIL:     state_next = (fit_end < {1'b0, limit}) ? S_INS_PUT : S_FIN;
            S_INS_RD:   state_next = S_INS_WR;
            S_INS_WR:   state_next = (idx_reg == pos_reg) ? S_INS_PUT : S_INS_RD;
            S_INS_PUT:  state_next = S_FIN;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK:
            begin
                if (rd_start == where_reg)
                    state_next = (idx_inc == cnt_reg) ? S_DEL_DONE : S_DEL_RD;
                else
                    state_next = (idx_inc == cnt_reg) ? S_FIN : S_FREE_RD;
            end
            S_DEL_RD:   state_next = S_DEL_WR;
            S_DEL_WR:   state_next = (idx_inc == cnt_reg) ? S_DEL_DONE : S_DEL_RD;
            S_DEL_DONE: state_next = (op_reg == OP_RELOCATE) ? S_ALLOC : S_FIN;
            S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        prev_end_next   = prev_end_reg;
        size_next       = size_reg;
        where_next      = where_reg;
        new_start_next  = new_start_reg;
        op_next         = op_reg;
        reloc_next      = reloc_reg;
        res_stat_next   = res_stat_reg;
        res_gstart_next = res_gstart_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_stat_next   = out_stat_reg;
        out_gstart_next = out_gstart_reg;
        out_size_next   = out_size_reg;
        case (state_reg)
            S_IDLE:
            begin
                op_next         = operation;
                size_next       = alloc_bytes;
                where_next      = region_start;
                reloc_next      = 1'b0;
                idx_next        = '0;
                res_stat_next   = STAT_NOTFOUND;
                res_gstart_next = '0;
                res_size_next   = '0;
            end
            S_ALLOC:
            begin
                idx_next        = '0;
                pos_next        = '0;
                new_start_next  = '0;
                res_gstart_next = '0;
                res_size_next   = reloc_reg ? size_reg : '0;
                res_stat_next   = (cnt_reg == MAX_CNT) ? STAT_FULL : STAT_NOMEM;
            end
            S_SCAN_CHK:
            begin
                if (idx_reg == '0 && size_reg < rd_start)
                begin
                    pos_next       = '0;
                    new_start_next = '0;
                    idx_next       = cnt_reg - ONE;
                end
                else if (idx_reg != '0 && fit_end <= {2'b00, rd_start})
                begin
                    pos_next       = idx_reg;
                    new_start_next = prev_end_reg[OFFS_W-1:0];
                    idx_next       = cnt_reg - ONE;
                end
                else
                begin
                    prev_end_next = rd_end;
                    idx_next      = idx_inc;
                end
            end
            S_TAIL:
            begin
                pos_next       = cnt_reg;
                new_start_next = prev_end_reg[OFFS_W-1:0];
            end
            S_INS_WR:
            begin
                idx_next = idx_dec;
            end
            S_INS_PUT:
            begin
                cnt_next        = cnt_reg + ONE;
                res_stat_next   = STAT_GRANTED;
                res_gstart_next = new_start_reg;
                res_size_next   = size_reg;
            end
            S_FREE_CHK:
            begin
                if (rd_start == where_reg)
                begin
                    size_next = rd_size;
                    pos_next  = idx_reg;
                end
                idx_next = idx_inc;
            end
            S_DEL_WR:
            begin
                idx_next = idx_inc;
            end
            S_DEL_DONE:
            begin
                cnt_next      = cnt_reg - ONE;
                reloc_next    = 1'b1;
                res_stat_next = STAT_FREED;
                res_size_next = size_reg;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_stat_next   = res_stat_reg;
                    out_gstart_next = res_gstart_reg;
                    out_size_next   = res_size_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc[AW-1:0];
            end
            S_DEL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec[AW-1:0];
            end
            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = {new_start_reg, size_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            reloc_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            reloc_reg     <= reloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        prev_end_reg   <= prev_end_next;
        size_reg       <= size_next;
        where_reg      <= where_next;
        new_start_reg  <= new_start_next;
        op_reg         <= op_next;
        res_stat_reg   <= res_stat_next;
        res_gstart_reg <= res_gstart_next;
        res_size_reg   <= res_size_next;
        out_stat_reg   <= out_stat_next;
        out_gstart_reg <= out_gstart_next;
        out_size_reg   <= out_size_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_stat_reg;
    assign granted_start = out_gstart_reg;
    assign region_size   = out_size_reg;

endmodule

// ===== design/ffra_checker.sv =====
`include "first_fit_region_allocator_assert.svh"

module ffra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [23:0] granted_start,
    input logic [23:0] region_size
);
    import ffra_pkg::*;

    `FFRA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `FFRA_ASSERT(a_status_legal, clk, rst_n, out_valid |-> status <= 3'(STAT_FULL), "illegal status code")
    `FFRA_ASSERT(a_start_zero, clk, rst_n, out_valid && status != 3'(STAT_GRANTED) |-> granted_start == '0, "start given without grant")
    `FFRA_ASSERT(a_size_zero, clk, rst_n, out_valid && (status == 3'(STAT_NOTFOUND) || status == 3'(STAT_FULL)) |-> region_size == '0, "size given on failure")

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_start (granted_start),
    .region_size   (region_size)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    import ffra_pkg::*;

    localparam int NREG = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [24:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [23:0] alloc_bytes = '0;
    logic [23:0] region_start = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [23:0] granted_start;
    logic [23:0] region_size;

    typedef struct packed {
        status_t     st;
        logic [23:0] gstart;
        logic [23:0] rsize;
    } answer_t;

    answer_t     pending_answers[$];
    logic [23:0] pool_starts[$];
    logic [23:0] pool_sizes[$];
    logic [24:0] pool_limit_shadow;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          drain_mode = 1'b0;
    bit          stall_hold = 1'b0;
    int          send_gap_max = 3;

    first_fit_region_allocator #(.MAX_REGIONS(NREG)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .alloc_bytes(alloc_bytes), .region_start(region_start),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .granted_start(granted_start), .region_size(region_size)
    );

    always #2 clk = ~clk;

    // First-fit placement on the shadow table; the returned status covers all outcomes.
    function automatic status_t place_region(input logic [23:0] sz, output logic [23:0] at);
        logic [25:0] cap;
        logic [25:0] tail_end;
        int n;
        n = pool_starts.size();
        cap = (pool_limit_shadow > LIMIT_CAP) ? 26'(LIMIT_CAP) : 26'(pool_limit_shadow);
        at = '0;
        if (n >= NREG) return STAT_FULL;
        if (sz == 0) return STAT_NOMEM;
        if (n == 0)
        begin
            if (26'(sz) < cap)
            begin
                pool_starts.push_back(24'd0);
                pool_sizes.push_back(sz);
                return STAT_GRANTED;
            end
            return STAT_NOMEM;
        end
        if (sz < pool_starts[0])
        begin
            pool_starts.insert(0, 24'd0);
            pool_sizes.insert(0, sz);
            return STAT_GRANTED;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            tail_end = 26'(pool_starts[i]) + 26'(pool_sizes[i]);
            if (tail_end + 26'(sz) <= 26'(pool_starts[i+1]))
            begin
                at = tail_end[23:0];
                pool_starts.insert(i + 1, at);
                pool_sizes.insert(i + 1, sz);
                return STAT_GRANTED;
            end
        end
        tail_end = 26'(pool_starts[n-1]) + 26'(pool_sizes[n-1]);
        if (tail_end + 26'(sz) < cap)
        begin
            at = tail_end[23:0];
            pool_starts.push_back(at);
            pool_sizes.push_back(sz);
            return STAT_GRANTED;
        end
        return STAT_NOMEM;
    endfunction

    function automatic answer_t predict_answer(input op_t op, input logic [23:0] sz,
                                               input logic [23:0] where);
        answer_t a;
        int hit;
        logic [23:0] at;
        a.st = STAT_NOTFOUND;
        a.gstart = '0;
        a.rsize = '0;
        hit = -1;
        if (op == OP_ALLOC)
        begin
            a.st = place_region(sz, at);
            a.gstart = at;
            if (a.st == STAT_GRANTED) a.rsize = sz;
        end
        else if (op == OP_FREE || op == OP_RELOCATE)
        begin
            foreach (pool_starts[i])
                if (hit < 0 && pool_starts[i] == where) hit = i;
            if (hit >= 0)
            begin
                a.rsize = pool_sizes[hit];
                pool_starts.delete(hit);
                pool_sizes.delete(hit);
                if (op == OP_FREE) a.st = STAT_FREED;
                else
                begin
                    a.st = place_region(a.rsize, at);
                    a.gstart = (a.st == STAT_GRANTED) ? at : 24'd0;
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result status", 24'(status), 24'd0);
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 24'(status), 24'(want.st));
                if (granted_start !== want.gstart)
                    report_mismatch("granted_start", granted_start, want.gstart);
                if (region_size !== want.rsize)
                    report_mismatch("region_size", region_size, want.rsize);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("first_fit_region_allocator verification failed");
            $finish;
        end
    end

    // Receiver stalls: mostly short, occasionally long, and held solid on request.
    always @(negedge clk)
    begin
        if (stall_hold) out_stall <= 1'b1;
        else if (drain_mode) out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < 30)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 2)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
        end
        else out_stall <= 1'b0;
    end

    task automatic send_request(input op_t op, input logic [23:0] sz, input logic [23:0] where);
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                           : $urandom_range(0, send_gap_max);
        // Valid was dropped at the last falling edge, so it stays low until a later falling edge.
        repeat (gap + 1) @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        alloc_bytes <= sz;
        region_start <= where;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_answers.push_back(predict_answer(op, sz, where));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic settle_block();
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (4 * NREG + 16) @(posedge clk);
    endtask

    task automatic write_limit(input logic [24:0] value);
        settle_block();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        pool_limit_shadow = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] some_start();
        if (pool_starts.size() != 0 && $urandom_range(0, 9) < 8)
            return pool_starts[$urandom_range(0, pool_starts.size() - 1)];
        return 24'($urandom);
    endfunction

    task automatic test_directed();
        send_request(OP_FREE, 24'd5, 24'd0);
        send_request(OP_RELOCATE, 24'd5, 24'd0);
        send_request(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OP_ALLOC, 24'd0, 24'd0);
        send_request(OP_ALLOC, 24'd409600, 24'd0);
        send_request(OP_ALLOC, 24'd409599, 24'd0);
        send_request(OP_FREE, 24'd0, 24'd0);
        send_request(OP_ALLOC, 24'd100, 24'd0);
        send_request(OP_ALLOC, 24'd50, 24'd0);
        send_request(OP_ALLOC, 24'd30, 24'd0);
        send_request(OP_FREE, 24'd0, 24'd100);
        send_request(OP_ALLOC, 24'd50, 24'd0);
        send_request(OP_FREE, 24'd0, 24'd0);
        send_request(OP_ALLOC, 24'd100, 24'd0);
        send_request(OP_RELOCATE, 24'd0, 24'd150);
        send_request(OP_FREE, 24'd0, 24'd77);
        send_request(OP_ALLOC, 24'hFFFFFF, 24'd0);
        send_request(OP_ALLOC, 24'd1, 24'd0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NREG + 3; i++)
            send_request(OP_ALLOC, 24'($urandom_range(1, 40)), 24'($urandom));
        send_request(OP_RELOCATE, 24'd0, pool_starts[NREG / 2]);
        for (int i = 0; i < NREG; i++)
            send_request(OP_FREE, 24'($urandom), some_start());
    endtask

    task automatic test_limits();
        write_limit(25'd0);
        send_request(OP_ALLOC, 24'd1, 24'd0);
        write_limit(25'd1);
        send_request(OP_ALLOC, 24'd1, 24'd0);
        write_limit(25'd2);
        send_request(OP_ALLOC, 24'd1, 24'd0);
        send_request(OP_ALLOC, 24'd1, 24'd0);
        write_limit(25'h1FFFFFF);
        send_request(OP_ALLOC, 24'hFFFFFF, 24'd0);
        send_request(OP_ALLOC, 24'hFFFFFF, 24'd0);
        send_request(OP_RELOCATE, 24'd0, 24'd1);
        write_limit(25'd16777216);
        send_request(OP_ALLOC, 24'd1, 24'd0);
        send_request(OP_ALLOC, 24'hFFFFFF, 24'd0);
    endtask

    task automatic test_backpressure();
        stall_hold = 1'b1;
        send_gap_max = 0;
        fork
            begin
                for (int i = 0; i < 8; i++)
                    send_request(OP_ALLOC, 24'($urandom_range(1, 9)), 24'd0);
            end
            begin
                int held;
                held = 0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
                stall_hold = 1'b0;
            end
        join
        send_gap_max = 3;
    endtask

    task automatic test_random();
        logic [24:0] limits[4];
        op_t op;
        logic [23:0] sz;
        int r;
        limits[0] = 25'd1000;
        limits[1] = 25'd409600;
        limits[2] = 25'd16777216;
        limits[3] = 25'($urandom_range(100, 20000));
        for (int phase = 0; phase < 4; phase++)
        begin
            write_limit(limits[phase]);
            for (int i = 0; i < 320; i++)
            begin
                r = $urandom_range(0, 99);
                op = (r < 50) ? OP_ALLOC : (r < 80) ? OP_FREE : (r < 97) ? OP_RELOCATE
                                                                          : OP_UNUSED;
                r = $urandom_range(0, 9);
                if (r < 6) sz = 24'($urandom_range(1, 100));
                else if (r < 8) sz = 24'($urandom_range(1, 20000));
                else if (r < 9) sz = 24'($urandom);
                else sz = 24'd0;
                if (i % 8 == 0) send_gap_max = $urandom_range(0, 1) ? 0 : 6;
                send_request(op, sz, some_start());
            end
        end
    endtask

    initial
    begin
        pool_limit_shadow = LIMIT_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_limits();
        test_random();
        drain_mode = 1'b1;
        settle_block();
        if (mismatches == 0)
            $display("first_fit_region_allocator verification clean");
        else
            $display("first_fit_region_allocator verification failed");
        $finish;
    end

endmodule
